// ----- src/assert_macros.svh -----
// Assertion helpers shared by the checker files of this block.
// Both sample on the rising edge of clk and are switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define PHTU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be seen true.
`define PHTU_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- src/phtu_pkg.sv -----
package phtu_pkg;

  localparam int TIME_W     = 40;
  localparam int TEMP_W     = 16;
  localparam int MIN_W      = 20;
  localparam int MAX_W      = 27;
  localparam int FACTOR_W   = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;

  // Radix-4 restoring divider: two quotient bits per cycle over a 56-bit dividend.
  localparam int DIV_STEPS  = 28;
  localparam int DIV_CNT_W  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_FACTOR  = 3'd4;

  localparam logic signed [TEMP_W-1:0] BAND_LOW_RST     = 16'sd22963;
  localparam logic signed [TEMP_W-1:0] BAND_HIGH_RST    = 16'sd23117;
  localparam logic [MIN_W-1:0]         MIN_INTERVAL_RST = 20'd20000;
  localparam logic [MAX_W-1:0]         MAX_INTERVAL_RST = 27'd1000000;
  localparam logic [FACTOR_W-1:0]      WAIT_FACTOR_RST  = 9'd102;

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_OFF  = 2'd2;

  localparam logic MODE_STATUS = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [TIME_W-1:0]        now_time;
    logic [TIME_W-1:0]        sample_time;
    logic signed [TEMP_W-1:0] temperature;
    logic                     heater_reported;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        command;
    logic              poll_request;
    logic [TIME_W-1:0] next_wait;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_MUL_A, S_MUL_B, S_ACC_B, S_DIV,
    S_MUL_C, S_MUL_D, S_ACC_D, S_SAT, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_EVAL, OP_MUL_A, OP_MUL_B, OP_ACC_B, OP_DIV,
    OP_MUL_C, OP_MUL_D, OP_ACC_D, OP_SAT, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_compute;
    logic out_free;
  } dp_status_t;

endpackage

// ----- src/phtu_stream_if.sv -----
interface phtu_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/predictive_hysteresis_thermostat_unit.sv -----
// A time tick, or a status request that needs no prediction, goes from the evaluation
// state straight to the emit state; a status request that runs the prediction first
// passes the multiply, divide and saturate states. The radix-4 divider and the shared
// 28 x 20 multiplier serve one request at a time; a new one is taken once it is emitted.
// Reset (rst, synchronous, active high) restores the register defaults and clears all
// history, leaving the heater counted as commanded off at time zero.
module predictive_hysteresis_thermostat_unit (
  input  logic                            clk,
  input  logic                            rst,
  phtu_stream_if.sink                     in_ch,
  phtu_stream_if.source                   out_ch,
  input  logic                            cfg_we,
  input  logic [phtu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [phtu_pkg::CFG_DATA_W-1:0] cfg_data
);

  // The controller sequences one request at a time. A tick is decided in the
  // evaluation state alone: the command is checked against the hysteresis band and the
  // minimum command spacing, and a poll is raised once the clamped wait has run out
  // since the last status was received, and min_interval since the last poll.
  //
  // A status request that is newer than the stored sample, and that is heading
  // toward the active band edge, runs the prediction:
  //   1. |edge - temperature| * dt, built from two 16 x 20 partial products,
  //   2. divided by |temperature change| two quotient bits per cycle,
  //   3. scaled by wait_factor in two 28 x 9 partial products, shifted down by 8,
  //   4. saturated to 40 bits and stored as the estimated wait.
  // All multiplications share one multiplier in the datapath.
  //
  // The result sits in an output register, so a new request is taken while an
  // earlier result still waits for the sink; the controller only stalls at the end
  // of a request if that register is still occupied.

  phtu_pkg::ctrl_cmd_t  cmd;
  phtu_pkg::dp_status_t status;

  // A request is taken only while the controller is idle.
  assign in_ch.ready = (cmd.op == phtu_pkg::OP_LATCH);

  phtu_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .status   (status),
    .cmd      (cmd)
  );

  phtu_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_ch.data),
    .out_data  (out_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

endmodule

// ----- src/phtu_controller.sv -----
module phtu_controller (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  phtu_pkg::dp_status_t   status,
  output phtu_pkg::ctrl_cmd_t    cmd
);

  phtu_pkg::state_t state, state_next;
  logic [phtu_pkg::DIV_CNT_W-1:0] div_count;
  logic div_last;

  assign div_last = (div_count == phtu_pkg::DIV_CNT_W'(phtu_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= phtu_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_count <= '0;
    end else if (state == phtu_pkg::S_DIV) begin
      div_count <= div_count + 1'b1;
    end else begin
      div_count <= '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      phtu_pkg::S_IDLE: begin
        if (in_valid) state_next = phtu_pkg::S_EVAL;
      end
      phtu_pkg::S_EVAL: begin
        state_next = status.need_compute ? phtu_pkg::S_MUL_A : phtu_pkg::S_EMIT;
      end
      phtu_pkg::S_MUL_A: state_next = phtu_pkg::S_MUL_B;
      phtu_pkg::S_MUL_B: state_next = phtu_pkg::S_ACC_B;
      phtu_pkg::S_ACC_B: state_next = phtu_pkg::S_DIV;
      phtu_pkg::S_DIV: begin
        if (div_last) state_next = phtu_pkg::S_MUL_C;
      end
      phtu_pkg::S_MUL_C: state_next = phtu_pkg::S_MUL_D;
      phtu_pkg::S_MUL_D: state_next = phtu_pkg::S_ACC_D;
      phtu_pkg::S_ACC_D: state_next = phtu_pkg::S_SAT;
      phtu_pkg::S_SAT:   state_next = phtu_pkg::S_EMIT;
      phtu_pkg::S_EMIT: begin
        if (status.out_free) state_next = phtu_pkg::S_IDLE;
      end
      default: state_next = phtu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = phtu_pkg::OP_NONE;
    case (state)
      phtu_pkg::S_IDLE:  cmd.op = phtu_pkg::OP_LATCH;
      phtu_pkg::S_EVAL:  cmd.op = phtu_pkg::OP_EVAL;
      phtu_pkg::S_MUL_A: cmd.op = phtu_pkg::OP_MUL_A;
      phtu_pkg::S_MUL_B: cmd.op = phtu_pkg::OP_MUL_B;
      phtu_pkg::S_ACC_B: cmd.op = phtu_pkg::OP_ACC_B;
      phtu_pkg::S_DIV:   cmd.op = phtu_pkg::OP_DIV;
      phtu_pkg::S_MUL_C: cmd.op = phtu_pkg::OP_MUL_C;
      phtu_pkg::S_MUL_D: cmd.op = phtu_pkg::OP_MUL_D;
      phtu_pkg::S_ACC_D: cmd.op = phtu_pkg::OP_ACC_D;
      phtu_pkg::S_SAT:   cmd.op = phtu_pkg::OP_SAT;
      phtu_pkg::S_EMIT:  cmd.op = phtu_pkg::OP_EMIT;
      default:           cmd.op = phtu_pkg::OP_NONE;
    endcase
  end

endmodule

// ----- src/phtu_datapath.sv -----
module phtu_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  phtu_pkg::ctrl_cmd_t                 cmd,
  output phtu_pkg::dp_status_t                status,
  input  logic                                cfg_we,
  input  logic [phtu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [phtu_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  phtu_pkg::in_item_t                  in_data,
  output phtu_pkg::out_item_t                 out_data,
  output logic                                out_valid,
  input  logic                                out_ready
);

  // Configuration.
  logic signed [15:0] band_low, band_high;
  logic [19:0]        min_interval;
  logic [26:0]        max_interval;
  logic [8:0]         wait_factor;

  // Request under work.
  phtu_pkg::in_item_t item;

  // Controller state.
  logic               have_prev, prev_rep, heater_on;
  logic signed [15:0] prev_temp;
  logic [39:0]        prev_st, est_wait, last_rx, last_cmd, last_req;

  // Prediction working registers.
  logic [15:0] an, ad, rem;
  logic [39:0] dt;
  logic [47:0] prod;
  logic [64:0] acc;
  logic [1:0]  res_command;
  logic        res_poll;

  // Combinational helpers.
  logic [16:0] band_edge, num, den, num_neg, den_neg;
  logic [15:0] num_mag, den_mag;
  logic        newer, zero_case, is_tick, cmd_due, poll_due;
  logic [1:0]  cmd_code;
  logic [39:0] wait_c;
  logic [27:0] mul_x;
  logic [19:0] mul_y;
  logic [47:0] mul_p;
  logic [16:0] r1, r1d, r2, r2d;
  logic        ge1, ge2;

  assign is_tick   = (item.mode == phtu_pkg::MODE_TICK);
  assign band_edge = heater_on ? {band_high[15], band_high} : {band_low[15], band_low};
  assign num       = band_edge - {item.temperature[15], item.temperature};
  assign den       = {item.temperature[15], item.temperature} - {prev_temp[15], prev_temp};
  assign num_neg   = -num;
  assign den_neg   = -den;
  assign num_mag   = num[16] ? num_neg[15:0] : num[15:0];
  assign den_mag   = den[16] ? den_neg[15:0] : den[15:0];
  assign newer     = !have_prev || (item.sample_time > prev_st);
  // No crossing ahead: no change, already on the edge, or moving away from it.
  assign zero_case = (num == '0) || (den == '0) || (num[16] != den[16]);

  assign status.need_compute = !is_tick && have_prev && newer && !zero_case;
  assign status.out_free     = !out_valid || out_ready;

  always_comb begin
    if (est_wait < {20'b0, min_interval}) begin
      wait_c = {20'b0, min_interval};
    end else if (est_wait > {13'b0, max_interval}) begin
      wait_c = {13'b0, max_interval};
    end else begin
      wait_c = est_wait;
    end
  end

  assign cmd_due  = have_prev &&
                    ({1'b0, item.now_time} >= ({1'b0, last_cmd} + {21'b0, min_interval}));
  assign poll_due = ({1'b0, item.now_time} >= ({1'b0, last_rx} + {1'b0, wait_c})) &&
                    ({1'b0, item.now_time} >= ({1'b0, last_req} + {21'b0, min_interval}));

  always_comb begin
    cmd_code = phtu_pkg::CMD_NONE;
    if (is_tick && cmd_due) begin
      if (prev_temp <= band_low) begin
        if (!prev_rep) cmd_code = phtu_pkg::CMD_ON;
      end else if (prev_temp >= band_high) begin
        if (prev_rep) cmd_code = phtu_pkg::CMD_OFF;
      end
    end
  end

  // Shared multiplier, 28 x 20 bits.
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (cmd.op)
      phtu_pkg::OP_MUL_A: begin
        mul_x = {12'b0, an};
        mul_y = dt[19:0];
      end
      phtu_pkg::OP_MUL_B: begin
        mul_x = {12'b0, an};
        mul_y = dt[39:20];
      end
      phtu_pkg::OP_MUL_C: begin
        mul_x = acc[27:0];
        mul_y = {11'b0, wait_factor};
      end
      phtu_pkg::OP_MUL_D: begin
        mul_x = acc[55:28];
        mul_y = {11'b0, wait_factor};
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p = {20'b0, mul_x} * {28'b0, mul_y};

  // Two restoring division steps per cycle; quotient bits shift in at the bottom of acc.
  assign r1  = {rem, acc[55]};
  assign ge1 = (r1 >= {1'b0, ad});
  assign r1d = ge1 ? (r1 - {1'b0, ad}) : r1;
  assign r2  = {r1d[15:0], acc[54]};
  assign ge2 = (r2 >= {1'b0, ad});
  assign r2d = ge2 ? (r2 - {1'b0, ad}) : r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_low     <= phtu_pkg::BAND_LOW_RST;
      band_high    <= phtu_pkg::BAND_HIGH_RST;
      min_interval <= phtu_pkg::MIN_INTERVAL_RST;
      max_interval <= phtu_pkg::MAX_INTERVAL_RST;
      wait_factor  <= phtu_pkg::WAIT_FACTOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        phtu_pkg::CFG_BAND_LOW:     band_low     <= cfg_data[15:0];
        phtu_pkg::CFG_BAND_HIGH:    band_high    <= cfg_data[15:0];
        phtu_pkg::CFG_MIN_INTERVAL: min_interval <= cfg_data[19:0];
        phtu_pkg::CFG_MAX_INTERVAL: max_interval <= cfg_data[26:0];
        phtu_pkg::CFG_WAIT_FACTOR:  wait_factor  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      prev_rep  <= 1'b0;
      heater_on <= 1'b0;
      prev_temp <= '0;
      prev_st   <= '0;
      est_wait  <= '0;
      last_rx   <= '0;
      last_cmd  <= '0;
      last_req  <= '0;
    end else begin
      case (cmd.op)
        phtu_pkg::OP_EVAL: begin
          if (!is_tick) begin
            last_rx <= item.now_time;
            if (newer) begin
              prev_temp <= item.temperature;
              prev_st   <= item.sample_time;
              prev_rep  <= item.heater_reported;
              have_prev <= 1'b1;
              if (have_prev && zero_case) est_wait <= '0;
            end
          end else begin
            if (cmd_code != phtu_pkg::CMD_NONE) begin
              last_cmd  <= item.now_time;
              heater_on <= (cmd_code == phtu_pkg::CMD_ON);
            end
            if (poll_due) last_req <= item.now_time;
          end
        end
        phtu_pkg::OP_SAT: begin
          est_wait <= (acc[64:48] != '0) ? '1 : acc[47:8];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      phtu_pkg::OP_LATCH: item <= in_data;
      phtu_pkg::OP_EVAL: begin
        an          <= num_mag;
        ad          <= den_mag;
        dt          <= item.sample_time - prev_st;
        res_command <= cmd_code;
        res_poll    <= is_tick && poll_due;
      end
      phtu_pkg::OP_MUL_A: prod <= mul_p;
      phtu_pkg::OP_MUL_B: begin
        acc  <= {17'b0, prod};
        prod <= mul_p;
      end
      phtu_pkg::OP_ACC_B: begin
        acc <= acc + {9'b0, prod[35:0], 20'b0};
        rem <= '0;
      end
      phtu_pkg::OP_DIV: begin
        acc <= {acc[64:56], acc[53:0], ge1, ge2};
        rem <= r2d[15:0];
      end
      phtu_pkg::OP_MUL_C: prod <= mul_p;
      phtu_pkg::OP_MUL_D: begin
        acc  <= {17'b0, prod};
        prod <= mul_p;
      end
      phtu_pkg::OP_ACC_D: acc <= acc + {prod[36:0], 28'b0};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == phtu_pkg::OP_EMIT && status.out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == phtu_pkg::OP_EMIT && status.out_free) begin
      out_data.command      <= res_command;
      out_data.poll_request <= res_poll;
      out_data.next_wait    <= wait_c;
    end
  end

endmodule

// ----- src/phtu_checker.sv -----
`include "assert_macros.svh"

module phtu_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input phtu_pkg::out_item_t out_data
);

  logic [1:0] pending;
  logic       in_take, out_take;

  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  // Requests accepted whose result has not been taken yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_take} - {1'b0, out_take};
    end
  end

  `PHTU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
  `PHTU_NEVER(a_no_orphan, out_valid && (pending == 2'd0), "result without an accepted request")
  `PHTU_NEVER(a_depth, pending == 2'd3, "more than two requests in flight")
  `PHTU_ASSERT(a_fields, out_valid |-> ((out_data.command == phtu_pkg::CMD_NONE) || (out_data.command == phtu_pkg::CMD_ON) || (out_data.command == phtu_pkg::CMD_OFF)) && (out_data.next_wait[39:27] == '0), "malformed result")

endmodule

bind predictive_hysteresis_thermostat_unit phtu_checker u_phtu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// ----- tb/predictive_hysteresis_thermostat_unit_tb.sv -----
// Self-checking bench for the predictive hysteresis thermostat.
//
// Requests go in on in_ch and results come back on out_ch. Every request
// produces exactly one result, in order. A scoreboard object keeps its own copy
// of the thermostat state and registers, works out the result of every accepted
// request and compares it with what comes back from the block.
module predictive_hysteresis_thermostat_unit_tb;

  // The longest stretch with no handshake on either channel that a correct run
  // can show is the receiver hold-off (HOLD_CYCLES) plus one prediction.
  localparam int IDLE_LIMIT   = 20000;
  // Wait somewhat longer at the end than a predicting status request takes.
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 3000;
  localparam logic [63:0] TIME_TOP  = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] HALF_SPAN = 64'h80_0000_0000;

  // Predicts the result of each request from a private copy of the state and
  // holds the predictions until the matching results come back.
  class thermostat_scoreboard;
    localparam logic [phtu_pkg::TIME_W-1:0] WAIT_CEIL = {phtu_pkg::TIME_W{1'b1}};

    logic signed [phtu_pkg::TEMP_W-1:0] band_low, band_high;
    logic [phtu_pkg::MIN_W-1:0]         min_interval;
    logic [phtu_pkg::MAX_W-1:0]         max_interval;
    logic [phtu_pkg::FACTOR_W-1:0]      wait_factor;

    bit                                 have_prev, prev_heater, heater_on;
    logic signed [phtu_pkg::TEMP_W-1:0] prev_temp;
    logic [phtu_pkg::TIME_W-1:0]        prev_sample, est_wait, last_rx, last_cmd, last_poll;

    phtu_pkg::out_item_t pending[$];
    int                  errors;
    int                  results_checked;

    function new();
      band_low        = phtu_pkg::BAND_LOW_RST;
      band_high       = phtu_pkg::BAND_HIGH_RST;
      min_interval    = phtu_pkg::MIN_INTERVAL_RST;
      max_interval    = phtu_pkg::MAX_INTERVAL_RST;
      wait_factor     = phtu_pkg::WAIT_FACTOR_RST;
      have_prev       = 1'b0;
      prev_heater     = 1'b0;
      heater_on       = 1'b0;
      prev_temp       = '0;
      prev_sample     = '0;
      est_wait        = '0;
      last_rx         = '0;
      last_cmd        = '0;
      last_poll       = '0;
      errors          = 0;
      results_checked = 0;
    endfunction

    function void write_register(logic [phtu_pkg::CFG_IDX_W-1:0] idx,
                                 logic [phtu_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        phtu_pkg::CFG_BAND_LOW:     band_low     = value[phtu_pkg::TEMP_W-1:0];
        phtu_pkg::CFG_BAND_HIGH:    band_high    = value[phtu_pkg::TEMP_W-1:0];
        phtu_pkg::CFG_MIN_INTERVAL: min_interval = value[phtu_pkg::MIN_W-1:0];
        phtu_pkg::CFG_MAX_INTERVAL: max_interval = value[phtu_pkg::MAX_W-1:0];
        phtu_pkg::CFG_WAIT_FACTOR:  wait_factor  = value[phtu_pkg::FACTOR_W-1:0];
        default: ;
      endcase
    endfunction

    // With min above max, anything not below min lands on max.
    function logic [phtu_pkg::TIME_W-1:0] clamped_wait();
      if (est_wait < phtu_pkg::TIME_W'(min_interval)) return phtu_pkg::TIME_W'(min_interval);
      if (est_wait > phtu_pkg::TIME_W'(max_interval)) return phtu_pkg::TIME_W'(max_interval);
      return est_wait;
    endfunction

    // Linear extrapolation to the active band edge, scaled by wait_factor.
    function logic [phtu_pkg::TIME_W-1:0] time_to_edge(
        logic [phtu_pkg::TIME_W-1:0] dt, logic signed [phtu_pkg::TEMP_W-1:0] temp);
      int          edge_temp, to_edge, slope;
      logic [63:0] abs_to_edge, abs_slope, reach, scaled;
      edge_temp = heater_on ? int'(band_high) : int'(band_low);
      to_edge   = edge_temp - int'(temp);
      slope     = int'(temp) - int'(prev_temp);
      if (to_edge == 0 || slope == 0) return '0;
      // Moving away from the edge means no useful estimate.
      if ((to_edge < 0) != (slope < 0)) return '0;
      abs_to_edge = 64'((to_edge < 0) ? -to_edge : to_edge);
      abs_slope   = 64'((slope < 0) ? -slope : slope);
      reach       = abs_to_edge * 64'(dt) / abs_slope;
      scaled      = (reach >> 8) * 64'(wait_factor) +
                    (((reach & 64'hFF) * 64'(wait_factor)) >> 8);
      return (scaled > 64'(WAIT_CEIL)) ? WAIT_CEIL : scaled[phtu_pkg::TIME_W-1:0];
    endfunction

    function void note_request(phtu_pkg::in_item_t req);
      phtu_pkg::out_item_t         want;
      logic [63:0]                 now64;
      logic [phtu_pkg::TIME_W-1:0] wait_now;
      want.command      = phtu_pkg::CMD_NONE;
      want.poll_request = 1'b0;
      now64             = 64'(req.now_time);
      if (req.mode == phtu_pkg::MODE_STATUS) begin
        // The receive time is refreshed even by a stale sample.
        last_rx = req.now_time;
        if (!have_prev || req.sample_time > prev_sample) begin
          if (have_prev) begin
            est_wait = time_to_edge(req.sample_time - prev_sample, req.temperature);
          end
          prev_temp   = req.temperature;
          prev_sample = req.sample_time;
          prev_heater = req.heater_reported;
          have_prev   = 1'b1;
        end
        want.next_wait = clamped_wait();
      end else begin
        // Sums are formed in 64 bits so that they never wrap.
        if (have_prev && now64 >= 64'(last_cmd) + 64'(min_interval)) begin
          if (prev_temp <= band_low) begin
            if (!prev_heater) begin
              want.command = phtu_pkg::CMD_ON;
              last_cmd     = req.now_time;
              heater_on    = 1'b1;
            end
          end else if (prev_temp >= band_high) begin
            if (prev_heater) begin
              want.command = phtu_pkg::CMD_OFF;
              last_cmd     = req.now_time;
              heater_on    = 1'b0;
            end
          end
        end
        wait_now = clamped_wait();
        if (now64 >= 64'(last_rx) + 64'(wait_now) &&
            now64 >= 64'(last_poll) + 64'(min_interval)) begin
          want.poll_request = 1'b1;
          last_poll         = req.now_time;
        end
        want.next_wait = wait_now;
      end
      pending.push_back(want);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(phtu_pkg::out_item_t got);
      phtu_pkg::out_item_t want;
      results_checked++;
      if (pending.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.command !== want.command)
        report_mismatch($sformatf("command expected %0d got %0d", want.command, got.command));
      if (got.poll_request !== want.poll_request)
        report_mismatch($sformatf("poll_request expected %0d got %0d",
                                  want.poll_request, got.poll_request));
      if (got.next_wait !== want.next_wait)
        report_mismatch($sformatf("next_wait expected %0d got %0d",
                                  want.next_wait, got.next_wait));
    endtask

    task check_leftovers();
      if (pending.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", pending.size()));
    endtask
  endclass

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [phtu_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [phtu_pkg::CFG_DATA_W-1:0] cfg_data;

  phtu_stream_if #(.payload_t(phtu_pkg::in_item_t))  in_ch ();
  phtu_stream_if #(.payload_t(phtu_pkg::out_item_t)) out_ch ();

  predictive_hysteresis_thermostat_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  thermostat_scoreboard sb = new();

  // State of the well-formed stimulus stream: a running clock, the newest sample
  // stamp handed out, and a temperature that wanders around the band.
  logic [63:0]                now_clock;
  logic [63:0]                last_sample;
  int                         temp_walk;
  int                         walk_lo;
  int                         walk_hi;
  logic [phtu_pkg::MIN_W-1:0] cur_min;
  bit                         send_quiet;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one. A quiet stretch has none.
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 16);
    return $urandom_range(40, 250);
  endfunction

  function automatic logic [phtu_pkg::TIME_W-1:0] rand40();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[phtu_pkg::TIME_W-1:0];
  endfunction

  // A tick carries junk in the status-only fields; the block must ignore it.
  function automatic phtu_pkg::in_item_t tick_req(logic [63:0] now);
    phtu_pkg::in_item_t req;
    logic [31:0]        r;
    r                   = $urandom();
    req.mode            = phtu_pkg::MODE_TICK;
    req.now_time        = now[phtu_pkg::TIME_W-1:0];
    req.sample_time     = rand40();
    req.temperature     = r[phtu_pkg::TEMP_W-1:0];
    req.heater_reported = r[16];
    return req;
  endfunction

  function automatic phtu_pkg::in_item_t status_req(logic [63:0] now, logic [63:0] sample,
                                                    int temp, bit heater);
    phtu_pkg::in_item_t req;
    req.mode            = phtu_pkg::MODE_STATUS;
    req.now_time        = now[phtu_pkg::TIME_W-1:0];
    req.sample_time     = sample[phtu_pkg::TIME_W-1:0];
    req.temperature     = phtu_pkg::TEMP_W'(temp);
    req.heater_reported = heater;
    return req;
  endfunction

  // Random request. Nine in ten follow the plausible pattern of a live system:
  // time moves forward, samples get newer, temperatures drift near the band.
  // The rest is noise: time running backwards, time jumps, barely newer or
  // repeated sample stamps with wild temperatures.
  function automatic phtu_pkg::in_item_t next_request();
    int                 pick;
    int                 noise;
    logic [31:0]        r;
    logic [63:0]        sample;
    phtu_pkg::in_item_t req;
    pick = $urandom_range(0, 99);
    r    = $urandom();
    if (pick < 10) begin
      noise = $urandom_range(0, 9);
      if (noise < 4) begin
        req = tick_req(now_clock - 64'($urandom_range(0, 100000)));
      end else if (noise < 7 || noise == 9) begin
        sample = last_sample + 64'($urandom_range(0, 2));
        if (sample > last_sample) last_sample = sample;
        req = status_req(now_clock, sample,
                         (noise == 9) ? (r[0] ? -32768 : 32767) : int'($signed(r[15:0])),
                         r[17]);
      end else begin
        now_clock = now_clock + 64'($urandom_range(0, 1 << 24));
        req       = tick_req(now_clock);
      end
    end else if (pick < 55) begin
      now_clock = now_clock + 64'($urandom_range(0, 20000));
      if ($urandom_range(0, 99) < 6) begin
        // A stale sample: only the receive time moves.
        sample = last_sample - 64'($urandom_range(0, 1000));
      end else begin
        sample = now_clock - 64'($urandom_range(0, 300));
        if (sample <= last_sample) sample = last_sample + 1;
        last_sample = sample;
        if (now_clock < sample) now_clock = sample;
      end
      // Leaving the temperature alone now and then gives a zero change.
      if ($urandom_range(0, 99) >= 6) begin
        temp_walk = temp_walk + int'($urandom_range(0, 128)) - 64;
        if (temp_walk > walk_hi) temp_walk = walk_hi;
        if (temp_walk < walk_lo) temp_walk = walk_lo;
      end
      req = status_req(now_clock, sample, temp_walk, r[18]);
    end else begin
      now_clock = now_clock + 64'($urandom_range(0, int'(cur_min) / 2 + 8000));
      req       = tick_req(now_clock);
    end
    return req;
  endfunction

  // Offer one request and hold it until the block takes it. The valid line is
  // only lowered when a gap comes before the request.
  task automatic drive_request(phtu_pkg::in_item_t req);
    int gap;
    gap = pick_gap(send_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.data  = req;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Stop offering and wait until every result has come back. Checking at the
  // falling edge makes sure the last acceptance has already been noted.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // Writes all five registers on consecutive edges, then centers the
  // temperature walk on the new band.
  task automatic apply_settings(int lo, int hi, int mn, int mx, int wf);
    logic [phtu_pkg::CFG_IDX_W-1:0]  regs [5];
    logic [phtu_pkg::CFG_DATA_W-1:0] vals [5];
    regs = '{phtu_pkg::CFG_BAND_LOW, phtu_pkg::CFG_BAND_HIGH, phtu_pkg::CFG_MIN_INTERVAL,
             phtu_pkg::CFG_MAX_INTERVAL, phtu_pkg::CFG_WAIT_FACTOR};
    vals = '{phtu_pkg::CFG_DATA_W'(lo), phtu_pkg::CFG_DATA_W'(hi),
             phtu_pkg::CFG_DATA_W'(mn), phtu_pkg::CFG_DATA_W'(mx),
             phtu_pkg::CFG_DATA_W'(wf)};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_we    = 1'b1;
      cfg_index = regs[i];
      cfg_data  = vals[i];
      sb.write_register(regs[i], vals[i]);
    end
    @(negedge clk);
    cfg_we    = 1'b0;
    cur_min   = phtu_pkg::MIN_W'(mn);
    walk_lo   = ((lo < hi) ? lo : hi) - 400;
    walk_hi   = ((lo < hi) ? hi : lo) + 400;
    if (walk_lo < -32768) walk_lo = -32768;
    if (walk_hi > 32767) walk_hi = 32767;
    temp_walk = (lo + hi) / 2;
  endtask

  task automatic run_phase(int lo, int hi, int mn, int mx, int wf, int count);
    wait_drained();
    apply_settings(lo, hi, mn, mx, wf);
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) send_quiet = ($urandom_range(0, 3) == 0);
      drive_request(next_request());
    end
  endtask

  // Both channels are sampled at the rising edge, where the values driven at the
  // falling edge and the block's registered outputs are both settled.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.data);
    end
  end

  // Result side. Random stalls, quiet stretches, and from time to time a long
  // hold-off while the sender keeps offering, so that the block backs up and
  // stalls its input.
  initial begin : result_sink
    int stall_left;
    int next_hold;
    int cycle_cnt;
    bit quiet;
    stall_left    = 0;
    next_hold     = 400;
    cycle_cnt     = 0;
    quiet         = 1'b0;
    out_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      cycle_cnt++;
      if (cycle_cnt % 256 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (stall_left == 0 && sb.results_checked >= next_hold) begin
        stall_left = HOLD_CYCLES;
        next_hold  = next_hold + 700;
      end
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        if (!quiet) stall_left = pick_gap(1'b0);
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : main
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    now_clock   = '0;
    last_sample = '0;
    temp_walk   = 0;
    walk_lo     = -32768;
    walk_hi     = 32767;
    cur_min     = phtu_pkg::MIN_INTERVAL_RST;
    send_quiet  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed requests, run against the register values left by reset.
    // A tick before any sample: no command, and too early to poll.
    drive_request(tick_req(64'd0));
    // Still no sample, but late enough for the first poll.
    drive_request(tick_req(64'd30000));
    // The first sample is always taken, at the coldest temperature.
    drive_request(status_req(64'd31000, 64'd1000, -32768, 1'b0));
    // A sample that is not newer only refreshes the receive time.
    drive_request(status_req(64'd32000, 64'd1000, 32767, 1'b1));
    // A newer sample with no temperature change gives a zero wait.
    drive_request(status_req(64'd33000, 64'd2000, -32768, 1'b0));
    // Warming toward the lower edge gives a real estimate.
    drive_request(status_req(64'd34000, 64'd3000, -32000, 1'b0));
    // Cold and reported off: the heater is switched on.
    drive_request(tick_req(64'd60000));
    // Heater on, so the upper edge is active; already above it means a zero wait.
    drive_request(status_req(64'd61000, 64'd4000, 32767, 1'b1));
    // Too soon after the last command.
    drive_request(tick_req(64'd70000));
    // Hot and reported on: the heater is switched off.
    drive_request(tick_req(64'd90000));
    // Cooling toward the lower edge from above.
    drive_request(status_req(64'd91000, 64'd5000, 30000, 1'b1));
    // Sitting exactly on the edge gives a zero wait.
    drive_request(status_req(64'd92000, 64'd6000, 22963, 1'b0));
    // Moving away from the edge gives a zero wait.
    drive_request(status_req(64'd93000, 64'd7000, 23040, 1'b0));
    // A huge time step with a tiny change saturates the estimate.
    drive_request(status_req(64'd94000, HALF_SPAN, 23039, 1'b0));
    drive_request(tick_req(HALF_SPAN + 64'd100));
    // Time running backwards reaches no threshold.
    drive_request(tick_req(64'd1000));

    now_clock   = HALF_SPAN + 64'd200;
    last_sample = HALF_SPAN;

    // Random phases, each under its own register setting, the extremes among them.
    run_phase(22963, 23117, 20000, 1000000, 102, 250);
    run_phase(-32768, 32767, 0, 0, 0, 150);
    run_phase(32767, -32768, 1000000, 100000000, 256, 150);
    // Minimum above maximum.
    run_phase(5000, 5500, 50000, 10000, 200, 200);
    run_phase(-2560, -2304, 1, 100000000, 1, 250);
    run_phase(0, 256, 20000, 1000000, 255, 250);

    // Last phase runs just below the top of the time range, where the threshold
    // sums pass 40 bits, and ends on the largest stamps.
    wait_drained();
    now_clock   = TIME_TOP - 64'h4000_0000;
    last_sample = now_clock;
    run_phase(100, 300, 5000, 200000, 128, 250);
    drive_request(status_req(TIME_TOP, TIME_TOP, 32767, 1'b1));
    drive_request(tick_req(TIME_TOP));

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_leftovers();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
